// File: hw/rtl/coap_pkg.sv
// ----------------------------------------------------------------------------
// coap_pkg
// Shared types, codes and constants of the circle offset PD controller.
// ----------------------------------------------------------------------------
package coap_pkg;

  localparam int MUL_AW = 36;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int ACC_W  = 48;
  localparam int TRIG_W = 34;
  localparam int ANG_W  = 33;
  localparam int CFG_AW = 8;

  localparam int CORDIC_STEPS = 20;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [30:0] PHASE_STEP_K = 31'd1749927105;

  localparam logic [7:0] MODE_HOLD  = 8'd0;
  localparam logic [7:0] MODE_TRACK = 8'd1;

  typedef enum logic [1:0] {
    ST_TRACK   = 2'd0,
    ST_HOLD    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_POS_GAIN_X = 8'd0,
    REG_POS_GAIN_Y = 8'd1,
    REG_VEL_GAIN_X = 8'd2,
    REG_VEL_GAIN_Y = 8'd3,
    REG_ORBIT_RATE = 8'd4,
    REG_ORBIT_RAD  = 8'd5,
    REG_ORIGIN_X   = 8'd6,
    REG_ORIGIN_Y   = 8'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG_GO,
    S_TRIG,
    S_MUL_GO,
    S_MUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0]         mode;
    logic signed [31:0] own_pos_x;
    logic signed [31:0] own_pos_y;
    logic signed [31:0] own_vel_x;
    logic signed [31:0] own_vel_y;
    logic signed [31:0] leader_pos_x;
    logic signed [31:0] leader_pos_y;
    logic signed [31:0] leader_vel_x;
    logic signed [31:0] leader_vel_y;
    logic signed [31:0] leader_acc_x;
    logic signed [31:0] leader_acc_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic [1:0]         status;
  } out_item_t;

  function automatic logic signed [ANG_W-1:0] atan_turn(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [MUL_PW-1:0] v);
    logic signed [31:0] r;
    if (v > MUL_PW'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < MUL_PW'(-64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/coap_if.sv
// ----------------------------------------------------------------------------
// coap_if
// Valid/ready channels of the controller: tick in, command out, config write.
// ----------------------------------------------------------------------------
interface coap_tick_if import coap_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface coap_cmd_if import coap_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface coap_cfg_if import coap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [31:0]       data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
  modport mon    (input valid, input addr, input data, input ready);
endinterface

// File: hw/rtl/coap_serial_mul.sv
// ----------------------------------------------------------------------------
// coap_serial_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module coap_serial_mul import coap_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic                     done,
  output logic signed [MUL_PW-1:0] p
);

  localparam int CW = $clog2(MUL_BW);

  logic signed [MUL_AW:0]   hi;
  logic [MUL_BW-1:0]        lo;
  logic signed [MUL_AW-1:0] a_q;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic signed [MUL_AW:0]   addend;
  logic signed [MUL_AW:0]   sum;

  always_comb begin
    if (!lo[0]) begin
      addend = '0;
    end else if (cnt == CW'(MUL_BW - 1)) begin
      addend = -(MUL_AW + 1)'(a_q);
    end else begin
      addend = (MUL_AW + 1)'(a_q);
    end
    sum = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MUL_BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi  <= '0;
      lo  <= b;
      a_q <= a;
    end else if (busy) begin
      hi <= sum >>> 1;
      lo <= {sum[0], lo[MUL_BW-1:1]};
    end
  end

  assign p = MUL_PW'({hi, lo});

endmodule

// File: hw/rtl/coap_cordic.sv
// ----------------------------------------------------------------------------
// coap_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, with
// quadrant folding of the phase.
// ----------------------------------------------------------------------------
module coap_cordic import coap_pkg::*; #(
  parameter int TRIG_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              phase,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  localparam logic [31:0] MASK = ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);

  logic signed [TRIG_W-1:0] x, y;
  logic signed [ANG_W-1:0]  z;
  logic [4:0]               i;
  logic [1:0]               q;
  logic                     busy;
  logic [31:0]              a, a_q, z0;
  logic [1:0]               q0;
  logic signed [TRIG_W-1:0] xs, ys;

  always_comb begin
    a  = phase & MASK;
    a_q = a + 32'h2000_0000;
    q0 = a_q[31:30];
    z0 = a - {q0, 30'd0};
    xs = x >>> i;
    ys = y >>> i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (i == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_X0;
      y <= '0;
      z <= ANG_W'($signed(z0));
      q <= q0;
    end else if (busy) begin
      if (!z[ANG_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_turn(i);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_turn(i);
      end
    end
  end

  always_comb begin
    unique case (q)
      2'd0: begin cos_q = x;  sin_q = y;  end
      2'd1: begin cos_q = -y; sin_q = x;  end
      2'd2: begin cos_q = -x; sin_q = -y; end
      default: begin cos_q = y; sin_q = -x; end
    endcase
  end

endmodule

// File: hw/rtl/circle_offset_pd_accel_controller_unit.sv
// ----------------------------------------------------------------------------
// circle_offset_pd_accel_controller_unit
// Circle offset PD acceleration controller: cordic orbit reference and
// per-axis PD with feedforward, all products on one bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  tick     in   mode, own and leader position/velocity/acceleration
//  cmd      out  accel_x, accel_y, status
//  cfg      in   addr (register index), data
//
//  track request: a cordic run, then 13 products on the serial multiplier;
//  hold request: one product when the orbit has started, else none. One
//  request at a time.
//  Reset clears the gains to their defaults and the orbit state to zero.
//  A stalled command waits in the output register; the next request is
//  taken meanwhile. cfg is always ready.
// ----------------------------------------------------------------------------
module circle_offset_pd_accel_controller_unit import coap_pkg::*; #(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  coap_cfg_if.sink    cfg,
  coap_tick_if.sink   tick,
  coap_cmd_if.source  cmd
);

  localparam logic [3:0] STEP_RW    = 4'd0;
  localparam logic [3:0] STEP_RWW   = 4'd1;
  localparam logic [3:0] STEP_PX    = 4'd2;
  localparam logic [3:0] STEP_PY    = 4'd3;
  localparam logic [3:0] STEP_VX    = 4'd4;
  localparam logic [3:0] STEP_VY    = 4'd5;
  localparam logic [3:0] STEP_AX    = 4'd6;
  localparam logic [3:0] STEP_AY    = 4'd7;
  localparam logic [3:0] STEP_GPX   = 4'd8;
  localparam logic [3:0] STEP_GPY   = 4'd9;
  localparam logic [3:0] STEP_GVX   = 4'd10;
  localparam logic [3:0] STEP_GVY   = 4'd11;
  localparam logic [3:0] STEP_DELTA = 4'd12;

  logic [15:0]        pos_gain_x, pos_gain_y, vel_gain_x, vel_gain_y;
  logic signed [31:0] orbit_rate, origin_x, origin_y;
  logic [30:0]        orbit_radius;

  state_t state, state_next;
  logic [3:0]         step;
  in_item_t           item;
  status_t            status;
  logic               started;
  logic [31:0]        orbit_phase;
  logic signed [31:0] last_accel_x, last_accel_y;
  logic signed [31:0] rw, rww;
  logic signed [TRIG_W-1:0] c_q, s_q;
  logic signed [MUL_AW-1:0] tpx, tpy, tvx, tvy;
  logic signed [ACC_W-1:0]  ax, ay;
  logic               out_valid;
  out_item_t          out_data;

  logic               accept;
  logic               mul_start, cordic_start, mul_done, cordic_done, load_out;
  logic signed [MUL_AW-1:0] op_a;
  logic signed [MUL_BW-1:0] op_b;
  logic signed [MUL_PW-1:0] prod, p30, p24, p8;
  logic signed [31:0]       t30, t24;
  logic signed [ACC_W-1:0]  t8, ax_sum, ay_sum;
  logic signed [TRIG_W-1:0] c_new, s_new;
  logic signed [MUL_AW-1:0] pos_base_x, pos_base_y, vel_base_x, vel_base_y;

  assign accept    = tick.valid && tick.ready;
  assign cfg.ready = 1'b1;
  assign cmd.valid = out_valid;
  assign cmd.data  = out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain_x   <= 16'd128;
      pos_gain_y   <= 16'd128;
      vel_gain_x   <= 16'd51;
      vel_gain_y   <= 16'd51;
      orbit_rate   <= '0;
      orbit_radius <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_POS_GAIN_X: pos_gain_x   <= cfg.data[15:0];
        REG_POS_GAIN_Y: pos_gain_y   <= cfg.data[15:0];
        REG_VEL_GAIN_X: vel_gain_x   <= cfg.data[15:0];
        REG_VEL_GAIN_Y: vel_gain_y   <= cfg.data[15:0];
        REG_ORBIT_RATE: orbit_rate   <= cfg.data;
        REG_ORBIT_RAD:  orbit_radius <= cfg.data[30:0];
        REG_ORIGIN_X:   origin_x     <= cfg.data;
        REG_ORIGIN_Y:   origin_y     <= cfg.data;
        default: ;
      endcase
    end
  end

  coap_cordic #(.TRIG_BITS(TRIG_TABLE_BITS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .phase (orbit_phase),
    .done  (cordic_done),
    .cos_q (c_new),
    .sin_q (s_new)
  );

  coap_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (prod)
  );

  // operand select
  always_comb begin
    unique case (step)
      STEP_RW:    begin op_a = MUL_AW'($signed({1'b0, orbit_radius})); op_b = MUL_BW'(orbit_rate); end
      STEP_RWW:   begin op_a = MUL_AW'(rw);  op_b = MUL_BW'(orbit_rate); end
      STEP_PX:    begin op_a = MUL_AW'($signed({1'b0, orbit_radius})); op_b = c_q; end
      STEP_PY:    begin op_a = MUL_AW'($signed({1'b0, orbit_radius})); op_b = s_q; end
      STEP_VX:    begin op_a = MUL_AW'(rw);  op_b = s_q; end
      STEP_VY:    begin op_a = MUL_AW'(rw);  op_b = c_q; end
      STEP_AX:    begin op_a = MUL_AW'(rww); op_b = c_q; end
      STEP_AY:    begin op_a = MUL_AW'(rww); op_b = s_q; end
      STEP_GPX:   begin op_a = tpx; op_b = MUL_BW'($signed({1'b0, pos_gain_x})); end
      STEP_GPY:   begin op_a = tpy; op_b = MUL_BW'($signed({1'b0, pos_gain_y})); end
      STEP_GVX:   begin op_a = tvx; op_b = MUL_BW'($signed({1'b0, vel_gain_x})); end
      STEP_GVY:   begin op_a = tvy; op_b = MUL_BW'($signed({1'b0, vel_gain_y})); end
      default:    begin op_a = MUL_AW'(orbit_rate);
                        op_b = MUL_BW'($signed({1'b0, PHASE_STEP_K})); end
    endcase
  end

  // product scaling
  always_comb begin
    p30    = prod >>> 30;
    p24    = prod >>> 24;
    p8     = prod >>> 8;
    t30    = sat32(p30);
    t24    = sat32(p24);
    t8     = p8[ACC_W-1:0];
    ax_sum = ax + t8;
    ay_sum = ay + t8;
    pos_base_x = MUL_AW'(item.leader_pos_x) - MUL_AW'(origin_x) - MUL_AW'(item.own_pos_x);
    pos_base_y = MUL_AW'(item.leader_pos_y) - MUL_AW'(origin_y) - MUL_AW'(item.own_pos_y);
    vel_base_x = MUL_AW'(item.leader_vel_x) - MUL_AW'(item.own_vel_x);
    vel_base_y = MUL_AW'(item.leader_vel_y) - MUL_AW'(item.own_vel_y);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (tick.data.mode == MODE_TRACK) begin
            state_next = S_TRIG_GO;
          end else if (started) begin
            state_next = S_MUL_GO;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_TRIG_GO: state_next = S_TRIG;
      S_TRIG:    if (cordic_done) state_next = S_MUL_GO;
      S_MUL_GO:  state_next = S_MUL;
      S_MUL: begin
        if (mul_done) begin
          state_next = (step == STEP_DELTA) ? S_OUT : S_MUL_GO;
        end
      end
      S_OUT:     if (!out_valid || cmd.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    tick.ready   = (state == S_IDLE);
    cordic_start = (state == S_TRIG_GO);
    mul_start    = (state == S_MUL_GO);
    load_out     = (state == S_OUT) && (!out_valid || cmd.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      started      <= 1'b0;
      orbit_phase  <= '0;
      last_accel_x <= '0;
      last_accel_y <= '0;
      out_valid    <= 1'b0;
      step         <= STEP_RW;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= (tick.data.mode == MODE_TRACK) ? STEP_RW : STEP_DELTA;
        if (tick.data.mode == MODE_TRACK && !started) begin
          started     <= 1'b1;
          orbit_phase <= '0;
        end
      end
      if (state == S_MUL && mul_done) begin
        if (step != STEP_DELTA) begin
          step <= step + 1'b1;
        end else begin
          orbit_phase <= orbit_phase + prod[63:32];
        end
        if (step == STEP_GVX) begin
          last_accel_x <= sat32(MUL_PW'(ax_sum));
        end
        if (step == STEP_GVY) begin
          last_accel_y <= sat32(MUL_PW'(ay_sum));
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= tick.data;
      if (tick.data.mode == MODE_TRACK) begin
        status <= ST_TRACK;
      end else if (tick.data.mode == MODE_HOLD) begin
        status <= ST_HOLD;
      end else begin
        status <= ST_INVALID;
      end
    end
    if (state == S_TRIG && cordic_done) begin
      c_q <= c_new;
      s_q <= s_new;
    end
    if (state == S_MUL && mul_done) begin
      unique case (step)
        STEP_RW:  rw  <= t24;
        STEP_RWW: rww <= t24;
        STEP_PX:  tpx <= pos_base_x + MUL_AW'(t30);
        STEP_PY:  tpy <= pos_base_y + MUL_AW'(t30);
        STEP_VX:  tvx <= vel_base_x - MUL_AW'(t30);
        STEP_VY:  tvy <= vel_base_y + MUL_AW'(t30);
        STEP_AX:  ax  <= ACC_W'(item.leader_acc_x) - ACC_W'(t30);
        STEP_AY:  ay  <= ACC_W'(item.leader_acc_y) - ACC_W'(t30);
        STEP_GPX, STEP_GVX: ax <= ax_sum;
        STEP_GPY, STEP_GVY: ay <= ay_sum;
        default: ;
      endcase
    end
    if (load_out) begin
      out_data.accel_x <= last_accel_x;
      out_data.accel_y <= last_accel_y;
      out_data.status  <= status;
    end
  end

endmodule

// File: hw/rtl/coap_checker.sv
// ----------------------------------------------------------------------------
// coap_checker
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module coap_checker import coap_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      tick_valid,
  input logic      tick_ready,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input out_item_t cmd_data
);

  logic signed [31:0] prev_x, prev_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (cmd_valid && cmd_ready) begin
      prev_x <= cmd_data.accel_x;
      prev_y <= cmd_data.accel_y;
    end
  end

  // repeated command matches the last one delivered
  a_hold_repeats: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_data.status != ST_TRACK |->
      cmd_data.accel_x == prev_x && cmd_data.accel_y == prev_y)
    else $error("repeated command differs from last");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_data))
    else $error("stalled command changed");

  // when no command is pending, none appears in the cycle right after a request
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready && !cmd_valid |=> !cmd_valid)
    else $error("command without work");

endmodule

bind circle_offset_pd_accel_controller_unit coap_checker u_coap_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_data   (cmd.data)
);
